### design/extended_gcd_unit_core_defines.svh
// Assertion macros for the extended GCD unit checker
`ifndef EXTENDED_GCD_UNIT_CORE_DEFINES_SVH
`define EXTENDED_GCD_UNIT_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset
`define EGCD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("egcd check failed");
// Next-cycle implication checked outside reset
`define EGCD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("egcd check failed");
`endif

### design/egcd_pkg.sv
// Shared widths and types for the extended GCD unit
`timescale 1ns / 1ps
package egcd_pkg;
  localparam int OperandWidth = 32;
  localparam int CoeffWidth   = OperandWidth + 1;
  localparam int CntWidth     = $clog2(OperandWidth + 1);
  typedef logic [OperandWidth-1:0] opnd_t;
  typedef logic signed [CoeffWidth-1:0] coef_t;
  typedef logic [CntWidth-1:0] cnt_t;
endpackage

### design/extended_gcd_unit_core.sv
// Top level of the extended GCD unit: bit-serial division and coefficient update
`timescale 1ns / 1ps
// Extended Euclidean unit.
// Pulse start with in_operand_a / in_operand_b while busy is low; that beat
// is taken. The unit then runs Euclid steps r0,r1 -> r1, r0 mod r1 with the
// Bezout coefficients s and t. Each step is a restoring division that
// produces one quotient bit per cycle, then a coefficient pass that
// multiplies the quotient into s1 and t1 by shift-and-add, one quotient
// bit per cycle, and a retire state that updates r, s and t. The number
// of steps is data dependent, up to about 47 for 32-bit operands.
// The result beat sits on out_gcd_value, out_coeff_x, out_coeff_y for one
// cycle, marked by out_valid; the receiver cannot stall it. busy stays high
// from the accepted beat until the result cycle has ended.
// Reset (rst_n low, synchronous) drops any item in flight and returns to idle.
module extended_gcd_unit_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  egcd_pkg::opnd_t      in_operand_a,
  input  egcd_pkg::opnd_t      in_operand_b,
  output logic                 out_valid,
  output egcd_pkg::opnd_t      out_gcd_value,
  output egcd_pkg::coef_t      out_coeff_x,
  output egcd_pkg::coef_t      out_coeff_y
);
  import egcd_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DIV, S_MUL, S_STEP} state_t;

  state_t state_r;
  opnd_t  r0_r, r1_r;
  coef_t  s0_r, s1_r, t0_r, t1_r;
  // division: quotient shifts in from the bottom of q_r while remainder grows
  opnd_t  q_r;
  logic [OperandWidth:0] rem_r;
  cnt_t   cnt_r;
  // coefficient products accumulate q*s1 and q*t1
  coef_t  ps_r, pt_r, ms_r, mt_r;
  logic   out_valid_r;
  opnd_t  gcd_r;
  coef_t  x_r, y_r;

  logic [OperandWidth:0] rem_sh;
  logic                  rem_ge;

  assign rem_sh = {rem_r[OperandWidth-1:0], r0_r[OperandWidth-1]};
  assign rem_ge = rem_sh >= {1'b0, r1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          // hold off a new beat during the result cycle, where busy is still high
          if (start && !out_valid_r) begin
            r0_r    <= in_operand_a;
            r1_r    <= in_operand_b;
            s0_r    <= coef_t'(1);
            s1_r    <= '0;
            t0_r    <= '0;
            t1_r    <= coef_t'(1);
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (r1_r == '0) begin
            gcd_r       <= r0_r;
            x_r         <= s0_r;
            y_r         <= t0_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            rem_r   <= '0;
            q_r     <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // hold dividend bits in r0_r, rotating them out of the top
          r0_r <= {r0_r[OperandWidth-2:0], r0_r[OperandWidth-1]};
          rem_r <= rem_ge ? (rem_sh - {1'b0, r1_r}) : rem_sh;
          q_r   <= {q_r[OperandWidth-2:0], rem_ge};
          if (cnt_r == cnt_t'(OperandWidth - 1)) begin
            cnt_r   <= '0;
            ps_r    <= '0;
            pt_r    <= '0;
            ms_r    <= s1_r;
            mt_r    <= t1_r;
            state_r <= S_MUL;
          end else begin
            cnt_r <= cnt_r + cnt_t'(1);
          end
        end
        S_MUL: begin
          // advance: consume the low quotient bit, double the multiplicands
          if (q_r[0]) begin
            ps_r <= ps_r + ms_r;
            pt_r <= pt_r + mt_r;
          end
          ms_r <= ms_r <<< 1;
          mt_r <= mt_r <<< 1;
          q_r  <= q_r >> 1;
          if (cnt_r == cnt_t'(OperandWidth - 1)) begin
            state_r <= S_STEP;
          end else begin
            cnt_r <= cnt_r + cnt_t'(1);
          end
        end
        S_STEP: begin
          r0_r    <= r1_r;
          r1_r    <= rem_r[OperandWidth-1:0];
          s0_r    <= s1_r;
          s1_r    <= s0_r - ps_r;
          t0_r    <= t1_r;
          t1_r    <= t0_r - pt_r;
          state_r <= S_CHECK;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy          = (state_r != S_IDLE) || out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_gcd_value = gcd_r;
  assign out_coeff_x   = x_r;
  assign out_coeff_y   = y_r;
endmodule

### design/egcd_checker.sv
// Port-level checker for the extended GCD unit, bound to the top level
`timescale 1ns / 1ps
`include "extended_gcd_unit_core_defines.svh"
module egcd_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import egcd_pkg::*;
  `EGCD_ASSERT_NXT(a_take_busy, start && !busy, busy)
  `EGCD_ASSERT_NXT(a_one_beat, out_valid, !out_valid)
  `EGCD_ASSERT_IMP(a_valid_busy, out_valid, busy)
  `EGCD_ASSERT_NXT(a_no_early, start && !busy, !out_valid)
endmodule

bind extended_gcd_unit_core egcd_checker u_egcd_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);

### tb/sv/extended_gcd_unit_core_tb.sv
// Self-checking bench for the extended GCD unit: queued driver, strobe monitor, Bezout predictor
`timescale 1ns / 1ps
module extended_gcd_unit_core_tb;
  import egcd_pkg::*;

  // Cycles without any accepted beat before the run is declared hung.
  // Worst item: about 47 Euclid steps, plus sender gaps.
  localparam int StallLimit = 20000;
  localparam int RandomItems = 950;
  localparam int DirectedItems = 18;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
  } opnd_pair_t;

  typedef struct packed {
    opnd_t g;
    coef_t x;
    coef_t y;
  } bezout_t;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  opnd_t in_operand_a;
  opnd_t in_operand_b;
  logic  out_valid;
  opnd_t out_gcd_value;
  coef_t out_coeff_x;
  coef_t out_coeff_y;

  opnd_pair_t pending_q[$];
  bezout_t    bezout_q[$];
  int         err_cnt;
  int         sent_cnt;
  int         recv_cnt;
  int         idle_cycles;
  bit         stim_done;
  bit         hold_for_drain;
  int         burst_left;
  int         gap_left;

  extended_gcd_unit_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_gcd_value(out_gcd_value),
    .out_coeff_x  (out_coeff_x),
    .out_coeff_y  (out_coeff_y)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Iterative Euclid with coefficients held in 64-bit signed; the true values
  // stay within +/-(2^32-1), so truncation to the coefficient width is exact.
  function automatic bezout_t solve_bezout(opnd_t a, opnd_t b);
    logic [63:0] r0, r1, q, rn;
    longint s0, s1, t0, t1, sn, tn;
    bezout_t res;
    r0 = {32'd0, a};
    r1 = {32'd0, b};
    s0 = 1; s1 = 0; t0 = 0; t1 = 1;
    while (r1 != 0) begin
      q  = r0 / r1;
      rn = r0 - q * r1;
      sn = s0 - longint'(q) * s1;
      tn = t0 - longint'(q) * t1;
      r0 = r1; r1 = rn;
      s0 = s1; s1 = sn;
      t0 = t1; t1 = tn;
    end
    res.g = r0[OperandWidth-1:0];
    res.x = s0[CoeffWidth-1:0];
    res.y = t0[CoeffWidth-1:0];
    return res;
  endfunction

  function automatic opnd_t rand_opnd();
    opnd_t v;
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: v = $urandom_range(0, 15);
      1: v = $urandom_range(0, 1000);
      2: v = $urandom >> $urandom_range(0, 31);
      3: v = ~($urandom_range(0, 3));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Driver: hold a beat on the ports until the edge where busy is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (start && !busy) begin
      // beat taken at this edge; drop start and set up the next one later
      bezout_q = {bezout_q, solve_bezout(in_operand_a, in_operand_b)};
      sent_cnt <= sent_cnt + 1;
      start <= 1'b0;
      if (burst_left > 0) begin
        burst_left <= burst_left - 1;
      end else begin
        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
        burst_left <= $urandom_range(1, 8);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_q.size() > 0 && !(hold_for_drain && bezout_q.size() > 0)) begin
        opnd_pair_t p;
        p = pending_q.pop_front();
        in_operand_a <= p.a;
        in_operand_b <= p.b;
        start <= 1'b1;
      end
    end
  end

  // Monitor: each strobe carries one result beat; compare with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (bezout_q.size() == 0) begin
        $error("result beat with nothing expected: g=%0d", out_gcd_value);
        err_cnt = err_cnt + 1;
      end else begin
        bezout_t e;
        e = bezout_q.pop_front();
        recv_cnt <= recv_cnt + 1;
        if (out_gcd_value !== e.g) begin
          $error("gcd_value: expected %0d, actual %0d", e.g, out_gcd_value);
          err_cnt = err_cnt + 1;
        end
        if (out_coeff_x !== e.x) begin
          $error("coeff_x: expected %0d, actual %0d", e.x, out_coeff_x);
          err_cnt = err_cnt + 1;
        end
        if (out_coeff_y !== e.y) begin
          $error("coeff_y: expected %0d, actual %0d", e.y, out_coeff_y);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: %0d results still outstanding", bezout_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic add_pair(opnd_t a, opnd_t b);
    opnd_pair_t p;
    p.a = a;
    p.b = b;
    pending_q = {pending_q, p};
  endtask

  initial begin
    start = 1'b0;
    in_operand_a = '0;
    in_operand_b = '0;
    rst_n = 1'b0;
    err_cnt = 0;
    sent_cnt = 0;
    recv_cnt = 0;
    idle_cycles = 0;
    hold_for_drain = 1'b0;
    burst_left = 0;
    gap_left = 0;
    // directed: zero operands, extremes, a below b, equal, coprime Fibonacci run
    add_pair(32'd0, 32'd0);
    add_pair(32'd12345, 32'd0);
    add_pair(32'd0, 32'd777);
    add_pair('1, 32'd0);
    add_pair(32'd0, '1);
    add_pair('1, '1);
    add_pair('1, 32'd1);
    add_pair(32'd1, '1);
    add_pair('1, 32'hFFFF_FFFE);
    add_pair(32'd35, 32'd240);
    add_pair(32'd240, 32'd35);
    add_pair(32'd1, 32'd1);
    add_pair(32'd2971215073, 32'd1836311903);
    add_pair(32'd1836311903, 32'd2971215073);
    add_pair(32'h8000_0000, 32'h4000_0000);
    add_pair(32'hAAAA_AAAA, 32'h5555_5555);
    add_pair(32'h5555_5555, 32'hAAAA_AAAA);
    add_pair(32'd4294967291, 32'd65521);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // pause the sender once mid-run until the unit has drained completely
    wait (sent_cnt >= DirectedItems);
    for (int i = 0; i < RandomItems; i++) begin
      add_pair(rand_opnd(), rand_opnd());
    end
    wait (sent_cnt >= 400);
    hold_for_drain = 1'b1;
    wait (bezout_q.size() == 0);
    @(posedge clk);
    hold_for_drain = 1'b0;
    // every beat taken; its prediction is queued at the same edge
    wait (sent_cnt == DirectedItems + RandomItems);
    wait (bezout_q.size() == 0);
    repeat (20) @(posedge clk);
    $display("covered %0d operand pairs, %0d result beats checked", sent_cnt, recv_cnt);
    $display("directed zero/extreme/swap cases plus random bursts with gaps");
    if (err_cnt == 0 && bezout_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+design
design/egcd_pkg.sv
design/extended_gcd_unit_core.sv
design/egcd_checker.sv
tb/sv/extended_gcd_unit_core_tb.sv
